// File: hdl/text_console_writer_defines.svh
// ----------------------------------------------------------------------------
// text_console_writer_defines
// assertion macros for the checker file of the console writer
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, sampled on clk and quiet while rst_n is low
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// types, codes and helpers shared by the text console writer modules
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  console;
        logic [7:0]  char_byte;
        logic [11:0] position;
        logic        last_of_write;
    } tcw_item_t;

    typedef struct packed {
        logic [10:0] cursor;
        logic [15:0] cell_value;
        logic [12:0] hardware_cursor;
        logic        scrolled;
    } tcw_result_t;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_SEEK  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam int         CFG_INDEX_W   = 2;
    localparam logic [1:0] CFG_ATTRIBUTE = 2'd0;
    localparam logic [1:0] CFG_SHOWN     = 2'd1;

    localparam logic [15:0] ATTRIBUTE_RESET = 16'h0700;
    localparam int          TAB_STEP        = 8;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CHAR,
        OP_NEWLINE,
        OP_TAB,
        OP_BACKSPACE,
        OP_SEEK,
        OP_READ
    } tcw_op_t;

    // classified command handed from the front end to the executor
    typedef struct packed {
        tcw_op_t     op;
        logic [1:0]  console;
        logic [7:0]  char_byte;
        logic [11:0] position;
        logic [7:0]  seek_col;
        logic        last_of_write;
    } tcw_cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } tcw_state_t;

    typedef struct packed {
        logic clearing;
    } tcw_status_t;

    // console number modulo count, for values below four
    function automatic logic [1:0] reduce_console(logic [1:0] v, int count);
        logic [1:0] r;
        r = v;
        for (int i = 0; i < 3; i++)
        begin
            if (int'(r) >= count)
            begin
                r = r - 2'(count);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// accepts input beats, clamps the position, splits seek targets into a
// column and classifies each beat into an executor command
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
    parameter int COLUMNS       = 80,
    parameter int ROWS          = 25,
    parameter int CONSOLE_COUNT = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire tcw_pkg::tcw_item_t   item,
    input  wire tcw_pkg::tcw_status_t status,
    output logic                      cmd_valid,
    input  wire logic                 cmd_ready,
    output tcw_pkg::tcw_cmd_t         cmd
);

    localparam int CELLS       = COLUMNS * ROWS;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = (1 << RECIP_SHIFT) / COLUMNS;
    localparam int QUOT_W      = $clog2((4096 / COLUMNS) + 1);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    tcw_pkg::tcw_item_t s1_item_reg;
    tcw_pkg::tcw_item_t s1_item_next;
    logic [QUOT_W-1:0]  s1_quot_reg;
    logic [QUOT_W-1:0]  s1_quot_next;

    logic [31:0]        recip_prod;
    logic [12:0]        quot_cols;
    logic [12:0]        remainder;
    logic               accept;

    assign item_ready = !status.clearing && (!s1_valid_reg || cmd_ready);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        s1_item_next         = item;
        s1_item_next.console = tcw_pkg::reduce_console(item.console, CONSOLE_COUNT);
        if (int'(item.position) > CELLS - 1)
        begin
            s1_item_next.position = 12'(CELLS - 1);
        end
        // quotient estimate by reciprocal, at most one short
        recip_prod   = 32'(s1_item_next.position) * 32'(RECIP);
        s1_quot_next = QUOT_W'(recip_prod >> RECIP_SHIFT);

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= s1_item_next;
            s1_quot_reg <= s1_quot_next;
        end
    end

    always_comb
    begin
        quot_cols = 13'(s1_quot_reg) * 13'(COLUMNS);
        remainder = {1'b0, s1_item_reg.position} - quot_cols;
        if (remainder >= 13'(COLUMNS))
        begin
            remainder = remainder - 13'(COLUMNS);
        end

        cmd.console       = s1_item_reg.console;
        cmd.char_byte     = s1_item_reg.char_byte;
        cmd.position      = s1_item_reg.position;
        cmd.seek_col      = 8'(remainder);
        cmd.last_of_write = s1_item_reg.last_of_write
                            && (s1_item_reg.mode == tcw_pkg::MODE_WRITE);

        case (s1_item_reg.mode)
            tcw_pkg::MODE_WRITE:
            begin
                case (s1_item_reg.char_byte)
                    tcw_pkg::CH_CR:  cmd.op = tcw_pkg::OP_NOP;
                    tcw_pkg::CH_NL:  cmd.op = tcw_pkg::OP_NEWLINE;
                    tcw_pkg::CH_TAB: cmd.op = tcw_pkg::OP_TAB;
                    tcw_pkg::CH_BS:  cmd.op = tcw_pkg::OP_BACKSPACE;
                    default:         cmd.op = tcw_pkg::OP_CHAR;
                endcase
            end
            tcw_pkg::MODE_SEEK: cmd.op = tcw_pkg::OP_SEEK;
            tcw_pkg::MODE_READ: cmd.op = tcw_pkg::OP_READ;
            default:            cmd.op = tcw_pkg::OP_NOP;
        endcase
    end

    assign cmd_valid = s1_valid_reg;

endmodule

`default_nettype wire

// File: hdl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// two-entry command queue between the front end and the executor
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire tcw_pkg::tcw_cmd_t push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output tcw_pkg::tcw_cmd_t      pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;
    localparam int CNT_W = 2;

    tcw_pkg::tcw_cmd_t entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// executor: cursors, cell store, scroll sequencer, configuration registers
// and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
    parameter int COLUMNS       = 80,
    parameter int ROWS          = 25,
    parameter int CONSOLE_COUNT = 4,
    parameter int PAGE_STRIDE   = 2048
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire tcw_pkg::tcw_cmd_t               cmd,
    output tcw_pkg::tcw_status_t                 status,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]                     cfg_data,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output tcw_pkg::tcw_result_t                 result
);

    localparam int CELLS          = COLUMNS * ROWS;
    localparam int TOTAL          = CONSOLE_COUNT * CELLS;
    localparam int ADDR_W         = $clog2(TOTAL);
    localparam int CUR_W          = $clog2(CELLS);
    localparam int COL_W          = $clog2(COLUMNS);
    localparam int TAB_W          = COL_W + 1;
    localparam int CON_W          = (CONSOLE_COUNT > 1) ? $clog2(CONSOLE_COUNT) : 1;
    localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;
    localparam int MOVE_N         = CELLS - COLUMNS;

    // cell store
    logic [15:0]          cell_mem [TOTAL];
    logic [15:0]          rd_data_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [15:0]          mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;

    // per-console cursors, linear and column
    logic [CUR_W-1:0]     cur_lin_reg [CONSOLE_COUNT];
    logic [COL_W-1:0]     cur_col_reg [CONSOLE_COUNT];
    logic                 cur_we;
    logic [CON_W-1:0]     cur_widx;
    logic [CON_W-1:0]     cur_ridx;
    logic [CUR_W-1:0]     sel_lin;
    logic [COL_W-1:0]     sel_col;

    tcw_pkg::tcw_state_t  state_reg;
    tcw_pkg::tcw_state_t  state_next;
    tcw_pkg::tcw_cmd_t    cmd_reg;
    tcw_pkg::tcw_cmd_t    cmd_next;
    logic [CUR_W-1:0]     lin_reg;
    logic [CUR_W-1:0]     lin_next;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [ADDR_W-1:0]    base_reg;
    logic [ADDR_W-1:0]    base_next;
    logic [CUR_W-1:0]     idx_reg;
    logic [CUR_W-1:0]     idx_next;
    logic [ADDR_W-1:0]    clr_reg;
    logic [ADDR_W-1:0]    clr_next;
    logic [15:0]          cell_reg;
    logic [15:0]          cell_next;
    logic                 scrolled_reg;
    logic                 scrolled_next;
    logic [15:0]          attr_reg;
    logic [15:0]          attr_next;
    logic [1:0]           shown_reg;
    logic [1:0]           shown_next;
    logic [12:0]          hw_reg;
    logic [12:0]          hw_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    tcw_pkg::tcw_result_t out_reg;
    tcw_pkg::tcw_result_t out_next;
    logic                 out_load;

    logic                 cfg_shown_wr;
    logic [1:0]           cfg_con;
    logic [ADDR_W-1:0]    cur_addr;
    logic [TAB_W-1:0]     tab_col;
    logic                 nl_scroll;
    logic [CUR_W-1:0]     nl_lin;
    logic                 is_shown;
    logic                 hw_reload;
    logic [12:0]          hw_item;

    assign cfg_ready       = 1'b1;
    assign cfg_shown_wr    = cfg_valid && (cfg_index == tcw_pkg::CFG_SHOWN);
    assign cfg_con         = tcw_pkg::reduce_console(cfg_data[1:0], CONSOLE_COUNT);
    assign cur_ridx        = CON_W'(cfg_shown_wr ? cfg_con : cmd.console);
    assign cur_widx        = CON_W'(cmd_reg.console);
    assign sel_lin         = cur_lin_reg[cur_ridx];
    assign sel_col         = cur_col_reg[cur_ridx];
    assign status.clearing = state_reg == tcw_pkg::ST_CLEAR;
    assign cmd_ready       = state_reg == tcw_pkg::ST_IDLE;
    assign result_valid    = out_valid_reg;
    assign result          = out_reg;

    assign cur_addr  = base_reg + ADDR_W'(lin_reg);
    assign tab_col   = (TAB_W'(col_reg) + TAB_W'(tcw_pkg::TAB_STEP))
                       & ~TAB_W'(tcw_pkg::TAB_STEP - 1);
    assign nl_scroll = lin_reg >= CUR_W'(LAST_ROW_START);
    assign nl_lin    = lin_reg - CUR_W'(col_reg) + CUR_W'(COLUMNS);
    assign is_shown  = cmd_reg.console == shown_reg;
    assign hw_reload = is_shown
                       && (cmd_reg.last_of_write || (cmd_reg.op == tcw_pkg::OP_SEEK));
    assign hw_item   = 13'(shown_reg) * 13'(PAGE_STRIDE) + 13'(lin_reg);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        lin_next       = lin_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        clr_next       = clr_reg;
        cell_next      = cell_reg;
        scrolled_next  = scrolled_reg;
        attr_next      = attr_reg;
        shown_next     = shown_reg;
        hw_next        = hw_reg;
        out_next       = out_reg;
        out_load       = 1'b0;
        cur_we         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cur_addr;
        mem_wdata      = attr_reg;
        mem_re         = 1'b0;
        mem_raddr      = base_reg + ADDR_W'(cmd_reg.position);

        case (state_reg)
            tcw_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == ADDR_W'(TOTAL - 1))
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            tcw_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next      = cmd;
                    lin_next      = sel_lin;
                    col_next      = sel_col;
                    base_next     = ADDR_W'(cmd.console) * ADDR_W'(CELLS);
                    cell_next     = '0;
                    scrolled_next = 1'b0;
                    state_next    = tcw_pkg::ST_EXEC;
                end
            end

            tcw_pkg::ST_EXEC:
            begin
                state_next = tcw_pkg::ST_DONE;
                case (cmd_reg.op)
                    tcw_pkg::OP_SEEK:
                    begin
                        lin_next = CUR_W'(cmd_reg.position);
                        col_next = COL_W'(cmd_reg.seek_col);
                    end

                    tcw_pkg::OP_READ:
                    begin
                        mem_re     = 1'b1;
                        state_next = tcw_pkg::ST_READ_WAIT;
                    end

                    tcw_pkg::OP_CHAR:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {8'h00, cmd_reg.char_byte} + attr_reg;
                        if (col_reg == COL_W'(COLUMNS - 1))
                        begin
                            if (nl_scroll)
                            begin
                                scrolled_next = 1'b1;
                                idx_next      = '0;
                                state_next    = tcw_pkg::ST_SCROLL;
                            end
                            else
                            begin
                                lin_next = nl_lin;
                                col_next = '0;
                            end
                        end
                        else
                        begin
                            lin_next = lin_reg + 1'b1;
                            col_next = col_reg + 1'b1;
                        end
                    end

                    tcw_pkg::OP_BACKSPACE:
                    begin
                        if (lin_reg != '0)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_addr - 1'b1;
                            lin_next  = lin_reg - 1'b1;
                            col_next  = (col_reg == '0) ? COL_W'(COLUMNS - 1)
                                                        : col_reg - 1'b1;
                        end
                    end

                    tcw_pkg::OP_TAB:
                    begin
                        if (tab_col >= TAB_W'(COLUMNS))
                        begin
                            if (nl_scroll)
                            begin
                                scrolled_next = 1'b1;
                                idx_next      = '0;
                                state_next    = tcw_pkg::ST_SCROLL;
                            end
                            else
                            begin
                                lin_next = nl_lin;
                                col_next = '0;
                            end
                        end
                        else
                        begin
                            lin_next = lin_reg - CUR_W'(col_reg) + CUR_W'(tab_col);
                            col_next = COL_W'(tab_col);
                        end
                    end

                    tcw_pkg::OP_NEWLINE:
                    begin
                        if (nl_scroll)
                        begin
                            scrolled_next = 1'b1;
                            idx_next      = '0;
                            state_next    = tcw_pkg::ST_SCROLL;
                        end
                        else
                        begin
                            lin_next = nl_lin;
                            col_next = '0;
                        end
                    end

                    default:
                    begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                endcase
            end

            tcw_pkg::ST_READ_WAIT:
            begin
                cell_next  = rd_data_reg;
                state_next = tcw_pkg::ST_DONE;
            end

            // read one row below, write the word fetched last cycle one slot back
            tcw_pkg::ST_SCROLL:
            begin
                mem_raddr = base_reg + ADDR_W'(idx_reg) + ADDR_W'(COLUMNS);
                mem_re    = idx_reg != CUR_W'(MOVE_N);
                mem_waddr = base_reg + ADDR_W'(idx_reg) - 1'b1;
                mem_wdata = rd_data_reg;
                mem_we    = idx_reg != '0;
                if (idx_reg == CUR_W'(MOVE_N))
                begin
                    state_next = tcw_pkg::ST_BLANK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            tcw_pkg::ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = base_reg + ADDR_W'(idx_reg);
                mem_wdata = attr_reg;
                if (idx_reg == CUR_W'(CELLS - 1))
                begin
                    lin_next   = CUR_W'(LAST_ROW_START);
                    col_next   = '0;
                    state_next = tcw_pkg::ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            tcw_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_load                 = 1'b1;
                    cur_we                   = 1'b1;
                    out_next.cursor          = 11'(lin_reg);
                    out_next.cell_value      = cell_reg;
                    out_next.hardware_cursor = hw_reload ? hw_item : hw_reg;
                    out_next.scrolled        = scrolled_reg;
                    hw_next                  = hw_reload ? hw_item : hw_reg;
                    state_next               = tcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase

        // the user lands configuration only while no beat is in flight; unchecked
        if (cfg_valid)
        begin
            case (cfg_index)
                tcw_pkg::CFG_ATTRIBUTE:
                begin
                    attr_next = cfg_data;
                end
                tcw_pkg::CFG_SHOWN:
                begin
                    shown_next = cfg_con;
                    hw_next    = 13'(cfg_con) * 13'(PAGE_STRIDE) + 13'(sel_lin);
                end
                default:
                begin
                    attr_next = attr_reg;
                end
            endcase
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_CLEAR;
            clr_reg       <= '0;
            attr_reg      <= tcw_pkg::ATTRIBUTE_RESET;
            shown_reg     <= '0;
            hw_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CONSOLE_COUNT; i++)
            begin
                cur_lin_reg[i] <= '0;
                cur_col_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            attr_reg      <= attr_next;
            shown_reg     <= shown_next;
            hw_reg        <= hw_next;
            out_valid_reg <= out_valid_next;
            if (cur_we)
            begin
                cur_lin_reg[cur_widx] <= lin_reg;
                cur_col_reg[cur_widx] <= col_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        lin_reg      <= lin_next;
        col_reg      <= col_next;
        base_reg     <= base_next;
        idx_reg      <= idx_next;
        cell_reg     <= cell_next;
        scrolled_reg <= scrolled_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cell_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// multi-console text terminal: character writes, cursor seeks, cell reads
//
// channel   handshake                    payload
// item      item_valid / item_ready      item (tcw_item_t)
// result    result_valid / result_ready  result (tcw_result_t)
// cfg       cfg_valid / cfg_ready        cfg_index, cfg_data
//
// executor steps per beat: idle, exec and done for a character, control
// byte or seek, with a read wait added for a cell read and a scroll and a
// blank walk added when a beat scrolls the page; the single-port-write cell
// store sets the scroll time, one cell a cycle; after reset the store is swept
// to zero with item_ready low; cfg writes are taken throughout
// a two-entry queue and a result register decouple input and output stalls
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS       = 80,
    parameter int ROWS          = 25,
    parameter int CONSOLE_COUNT = 4,
    parameter int PAGE_STRIDE   = 2048
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire tcw_pkg::tcw_item_t              item,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output tcw_pkg::tcw_result_t                 result,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]                     cfg_data
);

    tcw_pkg::tcw_status_t status;
    logic                 front_valid;
    logic                 front_ready;
    tcw_pkg::tcw_cmd_t    front_cmd;
    logic                 queue_valid;
    logic                 queue_ready;
    tcw_pkg::tcw_cmd_t    queue_cmd;

    tcw_front #(
        .COLUMNS       (COLUMNS),
        .ROWS          (ROWS),
        .CONSOLE_COUNT (CONSOLE_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .status     (status),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd)
    );

    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    tcw_back #(
        .COLUMNS       (COLUMNS),
        .ROWS          (ROWS),
        .CONSOLE_COUNT (CONSOLE_COUNT),
        .PAGE_STRIDE   (PAGE_STRIDE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (queue_valid),
        .cmd_ready    (queue_ready),
        .cmd          (queue_cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// File: hdl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks for the text console writer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_writer_defines.svh"

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 item_valid,
    input wire logic                 item_ready,
    input wire logic                 result_valid,
    input wire logic                 result_ready,
    input wire tcw_pkg::tcw_result_t result
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam bit CELLS_FIT = CELLS <= 2048;

    // beats taken in but not yet delivered
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg;
        if ((item_valid && item_ready) && !(result_valid && result_ready))
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (!(item_valid && item_ready) && (result_valid && result_ready))
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `TCW_ASSERT_NEXT(a_result_held, result_valid && !result_ready,
        result_valid && $stable(result), "result beat changed while stalled")

    `TCW_ASSERT_NOW(a_no_spurious_result, result_valid, inflight_reg != 3'd0,
        "result offered without an outstanding item")

    `TCW_ASSERT_NOW(a_scroll_cursor, result_valid && result.scrolled,
        result.cursor == 11'((ROWS - 1) * COLUMNS), "scroll left cursor off last row")

    `TCW_ASSERT_NOW(a_cursor_range, result_valid && CELLS_FIT,
        result.cursor <= 11'(CELLS - 1), "cursor beyond last cell")

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the text console writer: a behavioural model of the
// four console pages predicts every result beat, directed cases cover the
// control bytes, wrapping, scrolling and register extremes, then random text
// bursts, seeks and reads run under random idling and back-pressure
// ----------------------------------------------------------------------------
module tb;

    localparam int COLS         = 80;
    localparam int ROWS_N       = 25;
    localparam int CONSOLES     = 4;
    localparam int PAGE         = 2048;
    localparam int CELLS        = COLS * ROWS_N;
    localparam int SCROLL_CAP   = 120;
    localparam int RANDOM_ITEMS = 1850;
    localparam int LONG_HOLD    = 300;
    localparam int CFG_EVERY    = 300;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    tcw_pkg::tcw_item_t   item;
    logic                 result_valid;
    logic                 result_ready;
    tcw_pkg::tcw_result_t result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    // model of the terminal
    logic [15:0] screen [CONSOLES*CELLS];
    int          cursor_of [CONSOLES];
    logic [12:0] hw_cursor;
    logic [15:0] attr;
    logic [1:0]  shown;

    tcw_pkg::tcw_result_t awaited_replies [$];
    int          error_count  = 0;
    int          scroll_total = 0;
    int          useful_items = 0;
    bit          pacing_on    = 1'b1;
    bit          hold_request = 1'b0;

    text_console_writer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic void reset_model();
        for (int i = 0; i < CONSOLES * CELLS; i++)
        begin
            screen[i] = '0;
        end
        for (int c = 0; c < CONSOLES; c++)
        begin
            cursor_of[c] = 0;
        end
        hw_cursor = '0;
        attr      = tcw_pkg::ATTRIBUTE_RESET;
        shown     = '0;
    endfunction

    function automatic void reload_hw_cursor();
        int s;
        s = int'(shown) % CONSOLES;
        hw_cursor = 13'(s * PAGE + cursor_of[s]);
    endfunction

    // move to the next row, scrolling the page when already on the last one
    function automatic bit advance_line(int con);
        int row;
        int base;
        row  = cursor_of[con] / COLS;
        base = con * CELLS;
        if (row + 1 >= ROWS_N)
        begin
            for (int i = 0; i < CELLS - COLS; i++)
            begin
                screen[base + i] = screen[base + i + COLS];
            end
            for (int i = CELLS - COLS; i < CELLS; i++)
            begin
                screen[base + i] = attr;
            end
            cursor_of[con] = (ROWS_N - 1) * COLS;
            return 1'b1;
        end
        cursor_of[con] = (row + 1) * COLS;
        return 1'b0;
    endfunction

    function automatic tcw_pkg::tcw_result_t terminal_step(tcw_pkg::tcw_item_t it);
        tcw_pkg::tcw_result_t r;
        int          con;
        int          base;
        int          pos;
        int          cur;
        int          col;
        bit          rolled;
        con    = int'(it.console) % CONSOLES;
        base   = con * CELLS;
        pos    = (int'(it.position) > CELLS - 1) ? CELLS - 1 : int'(it.position);
        rolled = 1'b0;
        r      = '0;
        case (it.mode)
            tcw_pkg::MODE_WRITE:
            begin
                cur = cursor_of[con];
                case (it.char_byte)
                    tcw_pkg::CH_CR: ;
                    tcw_pkg::CH_NL: rolled = advance_line(con);
                    tcw_pkg::CH_TAB:
                    begin
                        col = ((cur % COLS) + tcw_pkg::TAB_STEP) & ~(tcw_pkg::TAB_STEP - 1);
                        if (col >= COLS)
                            rolled = advance_line(con);
                        else
                            cursor_of[con] = (cur / COLS) * COLS + col;
                    end
                    tcw_pkg::CH_BS:
                    begin
                        if (cur != 0)
                        begin
                            cursor_of[con] = cur - 1;
                            screen[base + cur - 1] = attr;
                        end
                    end
                    default:
                    begin
                        screen[base + cur] = 16'(int'(it.char_byte) + int'(attr));
                        if ((cur + 1) % COLS == 0)
                            rolled = advance_line(con);
                        else
                            cursor_of[con] = cur + 1;
                    end
                endcase
                if (it.last_of_write && con == int'(shown) % CONSOLES)
                    reload_hw_cursor();
            end
            tcw_pkg::MODE_SEEK:
            begin
                cursor_of[con] = pos;
                if (con == int'(shown) % CONSOLES)
                    reload_hw_cursor();
            end
            tcw_pkg::MODE_READ: r.cell_value = screen[base + pos];
            default: ;
        endcase
        if (rolled)
            scroll_total++;
        r.cursor          = 11'(cursor_of[con]);
        r.hardware_cursor = hw_cursor;
        r.scrolled        = rolled;
        return r;
    endfunction

    function automatic bit would_scroll(tcw_pkg::tcw_item_t it);
        int cur;
        cur = cursor_of[int'(it.console) % CONSOLES];
        if (it.mode != tcw_pkg::MODE_WRITE || cur / COLS != ROWS_N - 1)
            return 1'b0;
        case (it.char_byte)
            tcw_pkg::CH_CR, tcw_pkg::CH_BS: return 1'b0;
            tcw_pkg::CH_NL:                 return 1'b1;
            tcw_pkg::CH_TAB:
                return ((((cur % COLS) + tcw_pkg::TAB_STEP) & ~(tcw_pkg::TAB_STEP - 1))
                        >= COLS);
            default:                        return ((cur + 1) % COLS == 0);
        endcase
    endfunction

    function automatic tcw_pkg::tcw_item_t make_item(logic [1:0] mode, logic [1:0] con,
                                                     logic [7:0] ch, logic [11:0] pos,
                                                     logic last);
        tcw_pkg::tcw_item_t it;
        it.mode          = mode;
        it.console       = con;
        it.char_byte     = ch;
        it.position      = pos;
        it.last_of_write = last;
        return it;
    endfunction

    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13)
            return 8'($urandom_range(32, 126));
        else if (pick == 13)
            return tcw_pkg::CH_NL;
        else if (pick == 14)
            return tcw_pkg::CH_TAB;
        else if (pick == 15)
            return tcw_pkg::CH_BS;
        else if (pick == 16)
            return tcw_pkg::CH_CR;
        return 8'($urandom);
    endfunction

    function automatic logic [11:0] random_position();
        if ($urandom_range(0, 3) == 0)
            return 12'($urandom);
        return 12'($urandom_range(0, CELLS - 1));
    endfunction

    function automatic logic [15:0] random_attribute();
        case ($urandom_range(0, 4))
            0:       return tcw_pkg::ATTRIBUTE_RESET;
            1:       return {8'($urandom), 8'h00};
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // caller sits on a rising edge; valid stays high after the beat so that a
    // following item can go out back to back
    task automatic send_item(input tcw_pkg::tcw_item_t it);
        if (pacing_on && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        awaited_replies.push_back(terminal_step(it));
    endtask

    // scrolls cost a whole page walk, so past the cap they become seeks
    task automatic offer(input tcw_pkg::tcw_item_t it);
        if (scroll_total >= SCROLL_CAP && would_scroll(it))
        begin
            it.mode     = tcw_pkg::MODE_SEEK;
            it.position = 12'($urandom_range(0, CELLS - COLS - 1));
        end
        if (!(it.mode == MODE_UNUSED
              || (it.mode == tcw_pkg::MODE_WRITE && it.char_byte == tcw_pkg::CH_CR)))
            useful_items++;
        send_item(it);
    endtask

    task automatic wait_drain();
        item_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [tcw_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == tcw_pkg::CFG_ATTRIBUTE)
        begin
            attr = val;
        end
        else if (idx == tcw_pkg::CFG_SHOWN)
        begin
            shown = val[1:0];
            reload_hw_cursor();
        end
    endtask

    task automatic config_phase(input logic [15:0] attribute, input logic [1:0] page);
        wait_drain();
        write_register(tcw_pkg::CFG_ATTRIBUTE, attribute);
        write_register(tcw_pkg::CFG_SHOWN, {14'd0, page});
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        tcw_pkg::tcw_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                error_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                check_field("cursor", want.cursor, result.cursor);
                check_field("cell_value", want.cell_value, result.cell_value);
                check_field("hardware_cursor", want.hardware_cursor, result.hardware_cursor);
                check_field("scrolled", want.scrolled, result.scrolled);
            end
        end
    end

    initial
    begin : result_pacing
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                result_ready <= 1'b1;
            end
            else if (pacing_on && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                result_ready <= 1'b1;
            end
            else if (pacing_on && $urandom_range(0, 63) == 0)
            begin
                // a calm stretch with the sink always ready
                result_ready <= 1'b1;
                repeat ($urandom_range(30, 120)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // reset values of the registers, blank store, unused mode
    task automatic test_reset_state();
        offer(make_item(tcw_pkg::MODE_READ, 2'd0, 8'h00, 12'd0, 1'b0));
        offer(make_item(tcw_pkg::MODE_READ, 2'd3, 8'hFF, 12'hFFF, 1'b1));
        offer(make_item(MODE_UNUSED, 2'd2, 8'hFF, 12'hFFF, 1'b1));
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd0, 8'h41, 12'h000, 1'b1));
    endtask

    task automatic test_control_bytes();
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd0, tcw_pkg::CH_CR, 12'h000, 1'b0));
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd0, tcw_pkg::CH_TAB, 12'h000, 1'b0));
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd0, tcw_pkg::CH_BS, 12'h000, 1'b0));
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd0, tcw_pkg::CH_NL, 12'h000, 1'b0));
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd0, 8'h00, 12'h000, 1'b0));
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd0, 8'hFF, 12'h000, 1'b1));
        // backspace with the cursor already on cell zero
        offer(make_item(tcw_pkg::MODE_SEEK, 2'd0, 8'h00, 12'd0, 1'b0));
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd0, tcw_pkg::CH_BS, 12'h000, 1'b1));
        // last column wraps to the next row
        offer(make_item(tcw_pkg::MODE_SEEK, 2'd0, 8'h00, 12'd79, 1'b0));
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd0, 8'h5A, 12'h000, 1'b1));
        offer(make_item(tcw_pkg::MODE_READ, 2'd0, 8'h00, 12'd79, 1'b0));
    endtask

    task automatic test_scrolling();
        offer(make_item(tcw_pkg::MODE_SEEK, 2'd1, 8'h00, 12'd1999, 1'b0));
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd1, 8'h78, 12'h000, 1'b0));
        offer(make_item(tcw_pkg::MODE_SEEK, 2'd1, 8'h00, 12'd1995, 1'b0));
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd1, tcw_pkg::CH_TAB, 12'h000, 1'b0));
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd1, tcw_pkg::CH_NL, 12'h000, 1'b1));
        offer(make_item(tcw_pkg::MODE_READ, 2'd1, 8'h00, 12'd1999, 1'b0));
        offer(make_item(tcw_pkg::MODE_READ, 2'd1, 8'h00, 12'd1919, 1'b0));
    endtask

    task automatic test_register_extremes();
        config_phase(16'hFFFF, 2'd3);
        offer(make_item(tcw_pkg::MODE_SEEK, 2'd3, 8'h00, 12'd5, 1'b0));
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd3, 8'hFF, 12'h000, 1'b1));
        offer(make_item(tcw_pkg::MODE_READ, 2'd3, 8'h00, 12'd5, 1'b0));
        config_phase(16'h0000, 2'd1);
        offer(make_item(tcw_pkg::MODE_WRITE, 2'd1, tcw_pkg::CH_BS, 12'h000, 1'b1));
        offer(make_item(tcw_pkg::MODE_READ, 2'd1, 8'h00, 12'd1919, 1'b0));
        config_phase(tcw_pkg::ATTRIBUTE_RESET, 2'd0);
    endtask

    // sink holds off while text keeps coming, then the sender waits it out
    task automatic test_backpressure();
        tcw_pkg::tcw_item_t it;
        hold_request = 1'b1;
        // let the sink start holding off before any text goes out
        while (hold_request)
            @(posedge clk);
        for (int i = 0; i < 24; i++)
        begin
            it = make_item(tcw_pkg::MODE_WRITE, 2'($urandom), random_char(), 12'($urandom),
                           1'(i % 6 == 5));
            offer(it);
        end
        wait_drain();
        for (int i = 0; i < 8; i++)
        begin
            offer(make_item(tcw_pkg::MODE_READ, 2'($urandom), 8'($urandom),
                            random_position(), 1'b0));
        end
    endtask

    task automatic test_random_traffic();
        tcw_pkg::tcw_item_t it;
        int        kind;
        int        burst_len;
        int        next_cfg;
        useful_items = 0;
        next_cfg     = CFG_EVERY;
        while (useful_items < RANDOM_ITEMS)
        begin
            if (useful_items >= next_cfg)
            begin
                config_phase(random_attribute(), 2'($urandom));
                next_cfg += CFG_EVERY;
            end
            if (useful_items >= RANDOM_ITEMS - 250)
                pacing_on = 1'b0;
            it   = make_item(2'($urandom), 2'($urandom), 8'($urandom), 12'($urandom),
                             1'($urandom));
            kind = $urandom_range(0, 19);
            if (kind < 12)
            begin
                burst_len = $urandom_range(1, 16);
                for (int i = 0; i < burst_len; i++)
                begin
                    it.mode          = tcw_pkg::MODE_WRITE;
                    it.char_byte     = random_char();
                    it.position      = 12'($urandom);
                    it.last_of_write = (i == burst_len - 1) || ($urandom_range(0, 7) == 0);
                    offer(it);
                end
            end
            else if (kind < 15)
            begin
                it.mode     = tcw_pkg::MODE_SEEK;
                it.position = random_position();
                offer(it);
            end
            else if (kind < 18)
            begin
                it.mode     = tcw_pkg::MODE_READ;
                it.position = random_position();
                offer(it);
            end
            else if (kind == 18)
            begin
                it.mode = MODE_UNUSED;
                offer(it);
            end
            else
            begin
                // noise: every field random, any mode
                offer(it);
            end
        end
    endtask

    initial
    begin : run_all
        item_valid <= 1'b0;
        item       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= tcw_pkg::CFG_ATTRIBUTE;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_control_bytes();
        test_scrolling();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        wait_drain();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("text_console_writer test passed");
        else
            $display("text_console_writer test failed");
        $finish;
    end

    initial
    begin : watchdog
        #(30_000_000);
        $display("text_console_writer test failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_front.sv
hdl/tcw_queue.sv
hdl/tcw_back.sv
hdl/text_console_writer.sv
hdl/tcw_checker.sv
tb/tb.sv
